/* hdl/htfd_pkg.sv */
`default_nettype none
package htfd_pkg;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	localparam logic [14:0] TEMP_SPAN = 15'd17500;
	localparam logic [13:0] HUM_SPAN = 14'd10000;
	localparam logic [15:0] ROUND_HALF = 16'd32767;
	localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_CRC_ERR = 1'b1;

	// position of the next expected byte in the frame
	typedef enum logic [2:0] {
		POS_T_HI  = 3'd0,
		POS_T_LO  = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_HI  = 3'd3,
		POS_H_LO  = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_beat_t;

	typedef struct packed {
		logic signed [14:0] temperature_x100;
		logic [13:0]        rh_x100;
		logic               status;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [15:0] raw_humidity;
		logic        crc_ok;
	} frame_word_t;

	typedef struct packed {
		logic [30:0] temp_prod;
		logic [29:0] hum_prod;
		logic        crc_ok;
	} product_t;

	function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* hdl/htfd_frame.sv */
`default_nettype none
module htfd_frame (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rx_valid,
	output logic                       rx_ready,
	input  wire htfd_pkg::in_beat_t    rx_beat,
	output logic                       word_valid,
	input  wire logic                  word_ready,
	output htfd_pkg::frame_word_t      word
);

	htfd_pkg::pos_t pos_q, pos_eff, pos_d;
	logic [7:0]  crc_q, crc_d, crc_base, crc_upd;
	logic [15:0] raw_t_q, raw_t_d;
	logic [15:0] raw_h_q, raw_h_d;
	logic        first_ok_q, first_ok_d;
	logic        frame_done;
	logic        rx_fire;
	logic        word_valid_s1;
	htfd_pkg::frame_word_t word_s1;

	assign rx_ready = !word_valid_s1 || word_ready;
	assign rx_fire = rx_valid && rx_ready;

	// a start flag or an out-of-range position restarts the frame
	always_comb begin
		if (rx_beat.frame_start || (pos_q > htfd_pkg::POS_H_CRC)) begin
			pos_eff = htfd_pkg::POS_T_HI;
		end else begin
			pos_eff = pos_q;
		end
	end

	// next position
	always_comb begin
		case (pos_eff)
			htfd_pkg::POS_T_HI:  pos_d = htfd_pkg::POS_T_LO;
			htfd_pkg::POS_T_LO:  pos_d = htfd_pkg::POS_T_CRC;
			htfd_pkg::POS_T_CRC: pos_d = htfd_pkg::POS_H_HI;
			htfd_pkg::POS_H_HI:  pos_d = htfd_pkg::POS_H_LO;
			htfd_pkg::POS_H_LO:  pos_d = htfd_pkg::POS_H_CRC;
			default:             pos_d = htfd_pkg::POS_T_HI;
		endcase
	end

	// crc and word assembly
	always_comb begin
		crc_base = (pos_eff inside {htfd_pkg::POS_T_HI, htfd_pkg::POS_H_HI}) ?
			htfd_pkg::CRC_INIT : crc_q;
		crc_upd = htfd_pkg::crc8_update(crc_base, rx_beat.data_byte);
		crc_d = crc_q;
		raw_t_d = raw_t_q;
		raw_h_d = raw_h_q;
		first_ok_d = first_ok_q;
		frame_done = 1'b0;
		case (pos_eff)
			htfd_pkg::POS_T_HI: begin
				raw_t_d = {rx_beat.data_byte, 8'h00};
				crc_d = crc_upd;
			end
			htfd_pkg::POS_T_LO: begin
				raw_t_d = {raw_t_q[15:8], rx_beat.data_byte};
				crc_d = crc_upd;
			end
			htfd_pkg::POS_T_CRC: begin
				first_ok_d = (crc_q == rx_beat.data_byte);
				crc_d = htfd_pkg::CRC_INIT;
			end
			htfd_pkg::POS_H_HI: begin
				raw_h_d = {rx_beat.data_byte, 8'h00};
				crc_d = crc_upd;
			end
			htfd_pkg::POS_H_LO: begin
				raw_h_d = {raw_h_q[15:8], rx_beat.data_byte};
				crc_d = crc_upd;
			end
			default: begin
				crc_d = htfd_pkg::CRC_INIT;
				frame_done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= htfd_pkg::POS_T_HI;
			crc_q <= htfd_pkg::CRC_INIT;
			raw_t_q <= '0;
			raw_h_q <= '0;
			first_ok_q <= 1'b0;
		end else if (rx_fire) begin
			pos_q <= pos_d;
			crc_q <= crc_d;
			raw_t_q <= raw_t_d;
			raw_h_q <= raw_h_d;
			first_ok_q <= first_ok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_s1 <= 1'b0;
		end else if (rx_fire && frame_done) begin
			word_valid_s1 <= 1'b1;
		end else if (word_ready) begin
			word_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && frame_done) begin
			word_s1.raw_temperature <= raw_t_q;
			word_s1.raw_humidity <= raw_h_q;
			word_s1.crc_ok <= first_ok_q && (crc_q == rx_beat.data_byte);
		end
	end

	assign word_valid = word_valid_s1;
	assign word = word_s1;

endmodule
`default_nettype wire

/* hdl/htfd_mul.sv */
`default_nettype none
module htfd_mul (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  word_valid,
	output logic                       word_ready,
	input  wire htfd_pkg::frame_word_t word,
	output logic                       prod_valid,
	input  wire logic                  prod_ready,
	output htfd_pkg::product_t         prod
);

	logic               prod_valid_s2;
	htfd_pkg::product_t prod_s2;
	logic               word_fire;

	assign word_ready = !prod_valid_s2 || prod_ready;
	assign word_fire = word_valid && word_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s2 <= 1'b0;
		end else if (word_ready) begin
			prod_valid_s2 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_fire) begin
			prod_s2.temp_prod <= 31'(word.raw_temperature) * 31'(htfd_pkg::TEMP_SPAN);
			prod_s2.hum_prod <= 30'(word.raw_humidity) * 30'(htfd_pkg::HUM_SPAN);
			prod_s2.crc_ok <= word.crc_ok;
		end
	end

	assign prod_valid = prod_valid_s2;
	assign prod = prod_s2;

endmodule
`default_nettype wire

/* hdl/htfd_conv.sv */
`default_nettype none
module htfd_conv (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               prod_valid,
	output logic                    prod_ready,
	input  wire htfd_pkg::product_t prod,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output htfd_pkg::out_beat_t     res_beat
);

	logic [31:0] t_num, h_num, t_adj, h_adj;
	logic [15:0] t_quot, h_quot;
	logic signed [15:0] t_cels;
	logic        res_valid_s3;
	htfd_pkg::out_beat_t res_s3, res_d;
	logic        prod_fire;

	assign prod_ready = !res_valid_s3 || res_ready;
	assign prod_fire = prod_valid && prod_ready;

	// floor(n / 65535) as (n + (n >> 16) + 1) >> 16, exact for these ranges
	always_comb begin
		t_num = 32'(prod.temp_prod) + 32'(htfd_pkg::ROUND_HALF);
		h_num = 32'(prod.hum_prod) + 32'(htfd_pkg::ROUND_HALF);
		t_adj = t_num + (t_num >> 16) + 32'd1;
		h_adj = h_num + (h_num >> 16) + 32'd1;
		t_quot = t_adj[31:16];
		h_quot = h_adj[31:16];
		t_cels = signed'({1'b0, t_quot[14:0]}) - htfd_pkg::TEMP_OFFSET;
		if (prod.crc_ok) begin
			res_d.temperature_x100 = t_cels[14:0];
			res_d.rh_x100 = h_quot[13:0];
			res_d.status = htfd_pkg::STATUS_OK;
		end else begin
			res_d.temperature_x100 = '0;
			res_d.rh_x100 = '0;
			res_d.status = htfd_pkg::STATUS_CRC_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s3 <= 1'b0;
		end else if (prod_ready) begin
			res_valid_s3 <= prod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prod_fire) begin
			res_s3 <= res_d;
		end
	end

	assign res_valid = res_valid_s3;
	assign res_beat = res_s3;

endmodule
`default_nettype wire

/* hdl/humidity_temp_frame_decoder_top.sv */
// one beat accepted per cycle unless stalled; six beats make a frame and one result
// the sixth beat's result moves through the frame, multiply and divide registers
// the byte tracker sets throughput: one beat a cycle unless stalled, one result per six beats
// ready falls only when the result register and the stages behind it are all full
// asynchronous reset clears byte position, sets crc to 0xff and empties all stages
`default_nettype none
module humidity_temp_frame_decoder_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rx_valid,
	output logic                     rx_ready,
	input  wire htfd_pkg::in_beat_t  rx_beat,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output htfd_pkg::out_beat_t      res_beat
);

	logic                  word_valid, word_ready;
	htfd_pkg::frame_word_t word;
	logic                  prod_valid, prod_ready;
	htfd_pkg::product_t    prod;

	htfd_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_beat    (rx_beat),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word)
	);

	htfd_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod)
	);

	htfd_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_beat   (res_beat)
	);

`ifndef NO_ASSERTIONS
	// a decoded frame only shows up right after a byte beat was taken
	a_word_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(word_valid) |-> $past(rx_valid && rx_ready))
		else $error("frame word without accepted byte");

	// checksum failures carry zero measurements
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_beat.status == htfd_pkg::STATUS_CRC_ERR) |->
		(res_beat.temperature_x100 == 15'sd0 && res_beat.rh_x100 == 14'd0))
		else $error("crc error result with nonzero fields");

	// good results stay within the sensor scale
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_beat.status == htfd_pkg::STATUS_OK) |->
		(res_beat.rh_x100 <= 14'd10000 && res_beat.temperature_x100 >= -15'sd4500
		&& res_beat.temperature_x100 <= 15'sd13000))
		else $error("measurement out of range");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;

	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_ITEMS = 1100;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT = 400000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                rx_valid = 1'b0;
	logic                rx_ready;
	htfd_pkg::in_beat_t  rx_beat = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	htfd_pkg::out_beat_t res_beat;

	htfd_pkg::in_beat_t  byte_queue[$];
	htfd_pkg::out_beat_t expected_readings[$];
	int        errors = 0;
	int        cycle_count = 0;
	int        rx_gap = 0;
	int        rx_calm = 0;
	int        res_stall = 0;
	int        res_calm = 0;

	// decoder state as the block should hold it
	htfd_pkg::pos_t frame_pos = htfd_pkg::POS_T_HI;
	logic [7:0]  crc_acc = htfd_pkg::CRC_INIT;
	logic [15:0] raw_temp = '0;
	logic [15:0] raw_hum = '0;
	logic        temp_crc_ok = 1'b0;

	humidity_temp_frame_decoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_beat   (rx_beat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_beat  (res_beat)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] word_crc8(logic [15:0] w);
		return crc8_step(crc8_step(htfd_pkg::CRC_INIT, w[15:8]), w[7:0]);
	endfunction

	// mostly short gaps, a few long ones, and now and then a run with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			calm = $urandom_range(20, 80);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic start);
		htfd_pkg::in_beat_t beat;
		beat.data_byte = b;
		beat.frame_start = start;
		byte_queue.push_back(beat);
	endtask

	task automatic push_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
			input logic t_bad, input logic h_bad, input logic lead_start);
		logic [7:0] t_crc;
		logic [7:0] h_crc;
		t_crc = word_crc8(t_raw);
		h_crc = word_crc8(h_raw);
		if (t_bad)
			t_crc = t_crc ^ 8'($urandom_range(1, 255));
		if (h_bad)
			h_crc = h_crc ^ 8'($urandom_range(1, 255));
		push_byte(t_raw[15:8], lead_start);
		push_byte(t_raw[7:0], 1'b0);
		push_byte(t_crc, 1'b0);
		push_byte(h_raw[15:8], 1'b0);
		push_byte(h_raw[7:0], 1'b0);
		push_byte(h_crc, 1'b0);
	endtask

	task automatic decode_byte(input htfd_pkg::in_beat_t beat);
		logic [7:0]          b;
		logic                crc_match;
		longint unsigned     t_scaled;
		longint unsigned     h_scaled;
		htfd_pkg::out_beat_t reading;
		b = beat.data_byte;
		if (beat.frame_start) begin
			frame_pos = htfd_pkg::POS_T_HI;
			crc_acc = htfd_pkg::CRC_INIT;
		end
		case (frame_pos)
			htfd_pkg::POS_T_HI: begin
				raw_temp = {b, 8'h00};
				crc_acc = crc8_step(htfd_pkg::CRC_INIT, b);
			end
			htfd_pkg::POS_T_LO: begin
				raw_temp[7:0] = b;
				crc_acc = crc8_step(crc_acc, b);
			end
			htfd_pkg::POS_T_CRC: begin
				temp_crc_ok = (crc_acc == b);
				crc_acc = htfd_pkg::CRC_INIT;
			end
			htfd_pkg::POS_H_HI: begin
				raw_hum = {b, 8'h00};
				crc_acc = crc8_step(htfd_pkg::CRC_INIT, b);
			end
			htfd_pkg::POS_H_LO: begin
				raw_hum[7:0] = b;
				crc_acc = crc8_step(crc_acc, b);
			end
			default: begin
				crc_match = temp_crc_ok && (crc_acc == b);
				crc_acc = htfd_pkg::CRC_INIT;
				reading = '0;
				if (crc_match) begin
					t_scaled = (64'd17500 * raw_temp + 64'd32767) / 64'd65535;
					h_scaled = (64'd10000 * raw_hum + 64'd32767) / 64'd65535;
					reading.temperature_x100 = 15'(t_scaled - 64'd4500);
					reading.rh_x100 = 14'(h_scaled);
					reading.status = htfd_pkg::STATUS_OK;
				end else begin
					reading.status = htfd_pkg::STATUS_CRC_ERR;
				end
				expected_readings.push_back(reading);
			end
		endcase
		frame_pos = (frame_pos == htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_HI :
			htfd_pkg::pos_t'(frame_pos + 3'd1);
	endtask

	task automatic check_reading(input htfd_pkg::out_beat_t got);
		htfd_pkg::out_beat_t want;
		if (expected_readings.size() == 0) begin
			$display("%0t: unexpected result temp=%0d hum=%0d status=%0d", $time,
				got.temperature_x100, got.rh_x100, got.status);
			errors++;
			return;
		end
		want = expected_readings.pop_front();
		if (got.temperature_x100 !== want.temperature_x100 ||
				got.rh_x100 !== want.rh_x100 || got.status !== want.status) begin
			$display({"%0t: mismatch expected temp=%0d hum=%0d status=%0d,",
				" got temp=%0d hum=%0d status=%0d"},
				$time, want.temperature_x100, want.rh_x100, want.status,
				got.temperature_x100, got.rh_x100, got.status);
			errors++;
		end
	endtask

	// byte driver: predicts on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_beat <= '0;
		end else begin
			if (rx_valid && rx_ready)
				decode_byte(rx_beat);
			if (!rx_valid || rx_ready) begin
				if (rx_gap > 0) begin
					rx_gap--;
					rx_valid <= 1'b0;
				end else if (byte_queue.size() > 0) begin
					rx_beat <= byte_queue.pop_front();
					rx_valid <= 1'b1;
					rx_gap = pick_gap(rx_calm);
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready)
				check_reading(res_beat);
			if (res_stall > 0) begin
				res_stall--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				res_stall = pick_gap(res_calm);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int n_directed;
		int kind;
		int n_part;

		// first byte after reset without the start flag, all-zero words
		push_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
		// full-scale words: temperature above 125.00 and humidity at 100.00
		push_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		// partial frame dropped by a new start, then a bad temperature checksum
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
		// bad humidity checksum only
		push_frame(16'h8000, 16'h5555, 1'b0, 1'b1, 1'b1);

		n_directed = byte_queue.size();
		while (byte_queue.size() - n_directed < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				push_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, $urandom_range(0, 4) != 0);
			end else if (kind < 80) begin
				push_frame(pick_raw(), pick_raw(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'b1);
			end else if (kind < 90) begin
				n_part = $urandom_range(1, 5);
				for (int i = 0; i < n_part; i++)
					push_byte(8'($urandom_range(0, 255)), i == 0);
			end else begin
				push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() > 0 || rx_valid || expected_readings.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && expected_readings.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/htfd_pkg.sv
hdl/htfd_frame.sv
hdl/htfd_mul.sv
hdl/htfd_conv.sv
hdl/humidity_temp_frame_decoder_top.sv
tb/sv/tb.sv
